@@ sv/cdll_pkg.sv @@
package cdll_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_INSERT     = 3'd2,
        OP_SEARCH     = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_POP_BACK   = 3'd5,
        OP_DELETE     = 3'd6,
        OP_NOP        = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_FULL       = 3'd3,
        ST_BAD_HANDLE = 3'd4
    } status_t;

    // where the node memories are read, and where n is loaded from
    typedef enum logic [1:0] {
        RA_HEAD    = 2'd0,
        RA_HANDLE  = 2'd1,
        RA_NEXT_RD = 2'd2,
        RA_PREV_RD = 2'd3
    } raddr_sel_t;

    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_NEW  = 2'd1,
        RES_NODE = 2'd2
    } res_kind_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        raddr_sel_t raddr_sel;
        logic       n_load;
        logic       k_inc;
        logic       link_b;
        logic       link_c;
        logic       unlink;
        logic       res_set;
        status_t    res_status;
        res_kind_t  res_kind;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    empty;
        logic    full;
        logic    bad_handle;
        logic    match;
        logic    last;
        logic    out_busy;
    } stat_t;

endpackage

@@ sv/cdll_ctrl.sv @@
module cdll_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cdll_pkg::stat_t  stat,
    output cdll_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        IDLE,
        DECODE,
        LINK_B,
        LINK_C,
        WALK_CMP,
        POP_A,
        POP_B,
        UNLINK,
        RESP
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.raddr_sel  = cdll_pkg::RA_HEAD;
        cmd.res_status = cdll_pkg::ST_OK;
        cmd.res_kind   = cdll_pkg::RES_NONE;
        state_next     = state_reg;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = DECODE;
                end
            end
            DECODE: begin
                case (stat.op)
                    cdll_pkg::OP_PUSH_FRONT, cdll_pkg::OP_PUSH_BACK: begin
                        if (stat.full) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = cdll_pkg::ST_FULL;
                            state_next     = RESP;
                        end else begin
                            cmd.rd_en     = 1'b1;
                            cmd.raddr_sel = cdll_pkg::RA_HEAD;
                            state_next    = LINK_B;
                        end
                    end
                    cdll_pkg::OP_INSERT: begin
                        if (stat.bad_handle) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = cdll_pkg::ST_BAD_HANDLE;
                            state_next     = RESP;
                        end else if (stat.full) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = cdll_pkg::ST_FULL;
                            state_next     = RESP;
                        end else begin
                            cmd.rd_en     = 1'b1;
                            cmd.raddr_sel = cdll_pkg::RA_HANDLE;
                            state_next    = LINK_B;
                        end
                    end
                    cdll_pkg::OP_SEARCH, cdll_pkg::OP_DELETE,
                    cdll_pkg::OP_POP_FRONT, cdll_pkg::OP_POP_BACK: begin
                        if (stat.empty) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = cdll_pkg::ST_EMPTY;
                            state_next     = RESP;
                        end else begin
                            cmd.rd_en     = 1'b1;
                            cmd.raddr_sel = cdll_pkg::RA_HEAD;
                            cmd.n_load    = 1'b1;
                            if (stat.op == cdll_pkg::OP_SEARCH ||
                                stat.op == cdll_pkg::OP_DELETE) begin
                                state_next = WALK_CMP;
                            end else begin
                                state_next = POP_A;
                            end
                        end
                    end
                    default: begin
                        cmd.res_set = 1'b1;
                        state_next  = RESP;
                    end
                endcase
            end
            LINK_B: begin
                cmd.link_b = 1'b1;
                state_next = LINK_C;
            end
            LINK_C: begin
                cmd.link_c   = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_kind = cdll_pkg::RES_NEW;
                state_next   = RESP;
            end
            WALK_CMP: begin
                if (stat.match) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = cdll_pkg::RES_NODE;
                    state_next   = (stat.op == cdll_pkg::OP_DELETE) ? UNLINK : RESP;
                end else if (stat.last) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = cdll_pkg::ST_NOT_FOUND;
                    state_next     = RESP;
                end else begin
                    // follow next link, one node a cycle
                    cmd.rd_en     = 1'b1;
                    cmd.raddr_sel = cdll_pkg::RA_NEXT_RD;
                    cmd.n_load    = 1'b1;
                    cmd.k_inc     = 1'b1;
                end
            end
            POP_A: begin
                if (stat.op == cdll_pkg::OP_POP_FRONT) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = cdll_pkg::RES_NODE;
                    state_next   = UNLINK;
                end else begin
                    cmd.rd_en     = 1'b1;
                    cmd.raddr_sel = cdll_pkg::RA_PREV_RD;
                    cmd.n_load    = 1'b1;
                    state_next    = POP_B;
                end
            end
            POP_B: begin
                cmd.res_set  = 1'b1;
                cmd.res_kind = cdll_pkg::RES_NODE;
                state_next   = UNLINK;
            end
            UNLINK: begin
                cmd.unlink = 1'b1;
                state_next = RESP;
            end
            RESP: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

endmodule

@@ sv/cdll_datapath.sv @@
module cdll_datapath #(
    parameter int NODE_DEPTH = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cdll_pkg::cmd_t      cmd,
    output cdll_pkg::stat_t     stat,
    input  logic [2:0]          s_opcode,
    input  logic signed [31:0]  s_value,
    input  logic [7:0]          s_handle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [7:0]          m_node_handle,
    output logic signed [31:0]  m_node_value,
    output logic [8:0]          m_node_count
);

    localparam int IW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam int CW = $clog2(NODE_DEPTH + 1);

    logic [DATA_WIDTH-1:0] data_mem [NODE_DEPTH];
    logic [IW-1:0]         next_mem [NODE_DEPTH];
    logic [IW-1:0]         prev_mem [NODE_DEPTH];
    logic [IW-1:0]         fs_mem   [NODE_DEPTH];

    logic [DATA_WIDTH-1:0] data_rd_reg;
    logic [IW-1:0]         next_rd_reg, prev_rd_reg, fs_rd_reg;

    logic [NODE_DEPTH-1:0] in_use_reg;
    logic [CW-1:0]         ftop_reg, lw_reg, count_reg, k_reg;
    logic [IW-1:0]         head_reg, n_reg, a_reg, b_reg;

    cdll_pkg::opcode_t     op_reg;
    logic signed [DATA_WIDTH-1:0] v_reg;
    logic [7:0]            h_reg;

    cdll_pkg::status_t     res_status_reg;
    logic [IW-1:0]         res_handle_reg;
    logic signed [31:0]    res_value_reg;

    logic                  m_valid_reg;
    logic [2:0]            m_status_reg;
    logic [7:0]            m_handle_reg;
    logic signed [31:0]    m_value_reg;
    logic [8:0]            m_count_reg;

    logic [IW-1:0]         h_idx, raddr, fs_raddr, n_new, a_new, b_new;
    logic [CW-1:0]         ftop_dec;
    logic                  fresh;
    logic                  next_we, prev_we;
    logic [IW-1:0]         next_wa, next_wd, prev_wa, prev_wd;
    logic signed [DATA_WIDTH-1:0] data_rd_s;

    assign h_idx     = IW'(h_reg);
    assign ftop_dec  = ftop_reg - CW'(1);
    assign fs_raddr  = IW'(ftop_dec);
    // stack slots below the low-water mark were never rewritten
    assign fresh     = (ftop_dec < lw_reg);
    assign n_new     = fresh ? IW'(ftop_dec) : fs_rd_reg;
    assign data_rd_s = data_rd_reg;

    always_comb begin
        case (cmd.raddr_sel)
            cdll_pkg::RA_HEAD:    raddr = head_reg;
            cdll_pkg::RA_HANDLE:  raddr = h_idx;
            cdll_pkg::RA_NEXT_RD: raddr = next_rd_reg;
            cdll_pkg::RA_PREV_RD: raddr = prev_rd_reg;
            default:              raddr = head_reg;
        endcase
    end

    always_comb begin
        if (count_reg == '0) begin
            a_new = n_new;
            b_new = n_new;
        end else if (op_reg == cdll_pkg::OP_INSERT) begin
            a_new = h_idx;
            b_new = next_rd_reg;
        end else begin
            a_new = prev_rd_reg;
            b_new = head_reg;
        end
    end

    always_comb begin
        next_we = 1'b0;
        prev_we = 1'b0;
        next_wa = n_new;
        next_wd = b_new;
        prev_wa = n_new;
        prev_wd = a_new;
        if (cmd.link_b) begin
            next_we = 1'b1;
            prev_we = 1'b1;
        end else if (cmd.link_c) begin
            next_we = (count_reg != '0);
            prev_we = (count_reg != '0);
            next_wa = a_reg;
            next_wd = n_reg;
            prev_wa = b_reg;
            prev_wd = n_reg;
        end else if (cmd.unlink) begin
            next_we = (count_reg != CW'(1));
            prev_we = (count_reg != CW'(1));
            next_wa = prev_rd_reg;
            next_wd = next_rd_reg;
            prev_wa = next_rd_reg;
            prev_wd = prev_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            data_rd_reg <= data_mem[raddr];
            next_rd_reg <= next_mem[raddr];
            prev_rd_reg <= prev_mem[raddr];
            fs_rd_reg   <= fs_mem[fs_raddr];
        end
        if (cmd.link_b) begin
            data_mem[n_new] <= v_reg;
        end
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (cmd.unlink) begin
            fs_mem[IW'(ftop_reg)] <= n_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= cdll_pkg::opcode_t'(s_opcode);
            v_reg  <= DATA_WIDTH'(s_value);
            h_reg  <= s_handle;
        end
        if (cmd.n_load) begin
            n_reg <= raddr;
        end
        if (cmd.link_b) begin
            n_reg <= n_new;
            a_reg <= a_new;
            b_reg <= b_new;
        end
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_kind)
                cdll_pkg::RES_NEW: begin
                    res_handle_reg <= n_reg;
                    res_value_reg  <= 32'(v_reg);
                end
                cdll_pkg::RES_NODE: begin
                    res_handle_reg <= n_reg;
                    res_value_reg  <= 32'(data_rd_s);
                end
                default: begin
                    res_handle_reg <= '0;
                    res_value_reg  <= '0;
                end
            endcase
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_handle_reg <= 8'(res_handle_reg);
            m_value_reg  <= res_value_reg;
            m_count_reg  <= 9'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg  <= '0;
            ftop_reg    <= CW'(NODE_DEPTH);
            lw_reg      <= CW'(NODE_DEPTH);
            head_reg    <= '0;
            count_reg   <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                k_reg <= '0;
            end else if (cmd.k_inc) begin
                k_reg <= k_reg + CW'(1);
            end
            if (cmd.link_b) begin
                in_use_reg[n_new] <= 1'b1;
                ftop_reg          <= ftop_dec;
                if (fresh) begin
                    lw_reg <= ftop_dec;
                end
            end
            if (cmd.link_c) begin
                count_reg <= count_reg + CW'(1);
                if (count_reg == '0 || op_reg == cdll_pkg::OP_PUSH_FRONT) begin
                    head_reg <= n_reg;
                end
            end
            if (cmd.unlink) begin
                in_use_reg[n_reg] <= 1'b0;
                ftop_reg          <= ftop_reg + CW'(1);
                count_reg         <= count_reg - CW'(1);
                if (count_reg == CW'(1)) begin
                    head_reg <= '0;
                end else if (n_reg == head_reg) begin
                    head_reg <= next_rd_reg;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op         = op_reg;
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CW'(NODE_DEPTH)) || (ftop_reg == '0);
    assign stat.bad_handle = (32'(h_reg) >= NODE_DEPTH) || !in_use_reg[h_idx];
    assign stat.match      = (data_rd_reg == v_reg);
    assign stat.last       = ((k_reg + CW'(1)) == count_reg);
    assign stat.out_busy   = m_valid_reg && !m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_node_handle = m_handle_reg;
    assign m_node_value  = m_value_reg;
    assign m_node_count  = m_count_reg;

endmodule

@@ sv/circular_doubly_linked_list_engine.sv @@
// Steps: failed or unused commands DECODE, RESP; inserts DECODE, LINK_B, LINK_C, RESP;
// pops DECODE, POP_A, POP_B (back only), UNLINK, RESP; search and delete by value walk
// one node per cycle in WALK_CMP, then RESP (delete goes through UNLINK first).
// Throughput: one command at a time. A finished word waits in the output register.
// Reset (synchronous, aresetn low): empty list, full free stack, no output word.
module circular_doubly_linked_list_engine #(
    parameter int NODE_DEPTH = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_opcode,
    input  logic signed [31:0]  s_value,
    input  logic [7:0]          s_handle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [7:0]          m_node_handle,
    output logic signed [31:0]  m_node_value,
    output logic [8:0]          m_node_count
);

    cdll_pkg::cmd_t  cmd;
    cdll_pkg::stat_t stat;

    cdll_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cdll_datapath #(
        .NODE_DEPTH (NODE_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_opcode      (s_opcode),
        .s_value       (s_value),
        .s_handle      (s_handle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_node_handle (m_node_handle),
        .m_node_value  (m_node_value),
        .m_node_count  (m_node_count)
    );

endmodule
